// File: rtl/nearest_codeword_search_macros.svh
// Assertion macros shared by the nearest codeword search RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef NEAREST_CODEWORD_SEARCH_MACROS_SVH
`define NEAREST_CODEWORD_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

`define NCS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define NCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define NCS_ASSERT_IMPL(label, ante, cons)

`define NCS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/ncs_pkg.sv
// Types and constants of the nearest codeword search block.
// No dependencies; imported by every module of the block.
package ncs_pkg;

    localparam int ELEM_W     = 16;
    localparam int ROW_IDX_W  = 8;
    localparam int ELEM_IDX_W = 7;
    localparam int DIST_W     = 39;
    localparam int ABS_W      = 16;
    localparam int SQ_W       = 2 * ABS_W;
    localparam int CFG_DATA_W = 9;
    localparam int ROWS_REG_W = 9;
    localparam int DIMS_REG_W = 8;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [0:0] {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef enum logic [0:0] {
        REG_ROWS = 1'b0,
        REG_DIMS = 1'b1
    } cfg_reg_t;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct packed {
        kind_t                  kind;
        logic [ROW_IDX_W-1:0]   row_index;
        logic [ELEM_IDX_W-1:0]  element_index;
        logic signed [ELEM_W-1:0] element_value;
        logic                   last;
    } ncs_item_t;

    typedef struct packed {
        logic [ROW_IDX_W-1:0] nearest_index;
        logic [DIST_W-1:0]    min_distance;
    } ncs_result_t;

    typedef struct packed {
        logic valid;
        logic acc_en;
        logic zero_base;
        logic first;
        logic final_row;
        logic emit;
    } ncs_issue_t;

    typedef struct packed {
        logic clearing;
        logic pass_done;
    } ncs_status_t;

endpackage

// File: rtl/ncs_codebook.sv
// Codebook memory: one write port and one registered read port.
// Depends on ncs_pkg for the element type.
module ncs_codebook import ncs_pkg::*; #(
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  elem_t                    wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output elem_t                    rd_data
);

    elem_t mem [DEPTH];
    elem_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/ncs_mac.sv
// Shared distance unit: absolute difference, square, saturating accumulate and minimum tracking.
// Holds the accumulator memory and its clearing pass; depends on ncs_pkg and the macro header.
`include "nearest_codeword_search_macros.svh"

module ncs_mac import ncs_pkg::*; #(
    parameter int MAX_ROWS = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ncs_issue_t                  issue,
    input  logic [$clog2(MAX_ROWS)-1:0] issue_row,
    input  elem_t                       query_value,
    input  elem_t                       cb_data,
    output ncs_status_t                 status,
    output logic                        result_valid,
    output ncs_result_t                 result
);

    localparam int RW = $clog2(MAX_ROWS);

    logic [DIST_W-1:0] acc_mem [MAX_ROWS];
    logic [DIST_W-1:0] acc_rd_reg;

    logic          clear_reg;
    logic [RW-1:0] clr_row_reg;

    logic          s1_valid_reg;
    ncs_issue_t    s1_ctl_reg;
    logic [RW-1:0] s1_row_reg;

    logic              s2_valid_reg;
    ncs_issue_t        s2_ctl_reg;
    logic [RW-1:0]     s2_row_reg;
    logic [ABS_W-1:0]  s2_abs_reg;
    logic [DIST_W-1:0] s2_base_reg;

    logic              s3_valid_reg;
    ncs_issue_t        s3_ctl_reg;
    logic [RW-1:0]     s3_row_reg;
    logic [SQ_W-1:0]   s3_sq_reg;
    logic [DIST_W-1:0] s3_base_reg;

    logic [DIST_W-1:0] best_dist_reg;
    logic [RW-1:0]     best_row_reg;
    logic              result_valid_reg;
    ncs_result_t       result_reg;

    logic signed [ELEM_W:0] diff;
    logic [ABS_W-1:0]       abs_diff;
    logic [DIST_W:0]        sum;
    logic [DIST_W-1:0]      new_dist;
    logic                   take;
    logic [DIST_W-1:0]      cand_dist;
    logic [RW-1:0]          cand_row;
    logic                   acc_we;
    logic [RW-1:0]          acc_wa;
    logic [DIST_W-1:0]      acc_wd;

    always_comb
    begin
        diff     = (ELEM_W+1)'(cb_data) - (ELEM_W+1)'(query_value);
        abs_diff = diff[ELEM_W] ? ABS_W'(-diff) : ABS_W'(diff);
        sum      = {1'b0, s3_base_reg} + (DIST_W+1)'(s3_sq_reg);
        new_dist = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
        take      = s3_ctl_reg.first || (new_dist < best_dist_reg);
        cand_dist = take ? new_dist : best_dist_reg;
        cand_row  = take ? s3_row_reg : best_row_reg;
        if (clear_reg)
        begin
            acc_we = 1'b1;
            acc_wa = clr_row_reg;
            acc_wd = '0;
        end
        else
        begin
            acc_we = s3_valid_reg && s3_ctl_reg.acc_en;
            acc_wa = s3_row_reg;
            acc_wd = new_dist;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_wa] <= acc_wd;
        end
        if (issue.valid)
        begin
            acc_rd_reg <= acc_mem[issue_row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg        <= 1'b1;
            clr_row_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_reg)
            begin
                clr_row_reg <= clr_row_reg + RW'(1);
                if (clr_row_reg == RW'(MAX_ROWS - 1))
                begin
                    clear_reg <= 1'b0;
                end
            end
            s1_valid_reg     <= issue.valid;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            result_valid_reg <= s3_valid_reg && s3_ctl_reg.final_row && s3_ctl_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ctl_reg <= issue;
        s1_row_reg <= issue_row;

        s2_ctl_reg  <= s1_ctl_reg;
        s2_row_reg  <= s1_row_reg;
        s2_abs_reg  <= abs_diff;
        s2_base_reg <= s1_ctl_reg.zero_base ? '0 : acc_rd_reg;

        s3_ctl_reg  <= s2_ctl_reg;
        s3_row_reg  <= s2_row_reg;
        s3_sq_reg   <= s2_ctl_reg.acc_en ? s2_abs_reg * s2_abs_reg : '0;
        s3_base_reg <= s2_base_reg;

        if (s3_valid_reg)
        begin
            best_dist_reg <= cand_dist;
            best_row_reg  <= cand_row;
            if (s3_ctl_reg.final_row)
            begin
                result_reg.nearest_index <= ROW_IDX_W'(cand_row);
                result_reg.min_distance  <= cand_dist;
            end
        end
    end

    assign status.clearing  = clear_reg;
    assign status.pass_done = s3_valid_reg && s3_ctl_reg.final_row;
    assign result_valid     = result_valid_reg;
    assign result           = result_reg;

    `NCS_ASSERT_IMPL(a_no_issue_in_clear, issue.valid, !clear_reg)
    `NCS_ASSERT_NEXT(a_result_single, result_valid_reg, !result_valid_reg)
    `NCS_ASSERT_NEXT(a_result_follows, status.pass_done && s3_ctl_reg.emit, result_valid_reg)

endmodule

// File: rtl/nearest_codeword_search.sv
// Top level of the nearest codeword search block: configuration, sequencer and memories.
// Depends on ncs_pkg, ncs_codebook, ncs_mac and the macro header.
//
//   Channel   Signals                              Transaction
//   input     start, busy, item                    start high while busy is low
//   result    result_valid, result                 result_valid high for one cycle
//   config    cfg_valid, cfg_ready, cfg_index,     cfg_valid and cfg_ready both high
//             cfg_data
//
// A load item is written into the codebook and leaves the block ready at once.
// A query element makes one pass of the shared multiply-accumulate unit over the rows in use,
// one row per cycle, and then waits for the three pipeline stages to drain.
// A query element that is out of range and not marked last leaves the block ready at once.
// After reset the accumulator memory is cleared row by row while busy is high.
// The result strobe cannot be stalled; config writes are always taken.
`include "nearest_codeword_search_macros.svh"

module nearest_codeword_search import ncs_pkg::*; #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_DIM  = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ncs_item_t             item,
    output logic                  result_valid,
    output ncs_result_t           result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RW          = $clog2(MAX_ROWS);
    localparam int CB_DEPTH    = MAX_ROWS * MAX_DIM;
    localparam int CB_AW       = $clog2(CB_DEPTH);
    localparam int DCW         = $clog2(MAX_DIM + 1);
    localparam int DIMS_RESET  = (MAX_DIM < 128) ? MAX_DIM : 128;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT
    } state_t;

    state_t           state_reg;
    logic [RW-1:0]    row_reg;
    logic [CB_AW-1:0] addr_reg;
    elem_t            value_reg;
    logic             acc_en_reg;
    logic             zero_base_reg;
    logic             emit_reg;

    logic [RW-1:0]    last_row_reg;
    logic [RW-1:0]    last_row_next;
    logic [DCW-1:0]   dims_reg;
    logic [DCW-1:0]   dims_next;

    logic             accept;
    logic             is_query;
    logic             in_dim;
    logic             load_ok;
    logic [CB_AW-1:0] load_addr;
    ncs_issue_t       issue;
    ncs_status_t      status;
    elem_t            cb_data;

    always_comb
    begin
        int rows_c;
        int dims_c;
        rows_c = int'(cfg_data[ROWS_REG_W-1:0]);
        dims_c = int'(cfg_data[DIMS_REG_W-1:0]);
        if (rows_c == 0)
        begin
            rows_c = 1;
        end
        else if (rows_c > MAX_ROWS)
        begin
            rows_c = MAX_ROWS;
        end
        if (dims_c == 0)
        begin
            dims_c = 1;
        end
        else if (dims_c > MAX_DIM)
        begin
            dims_c = MAX_DIM;
        end
        last_row_next = RW'(rows_c - 1);
        dims_next     = DCW'(dims_c);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_row_reg <= '0;
            dims_reg     <= DCW'(DIMS_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROWS: last_row_reg <= last_row_next;
                REG_DIMS: dims_reg     <= dims_next;
                default:  ;
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE) || status.clearing;
    assign accept    = start && !busy;
    assign is_query  = (item.kind == KIND_QUERY);
    assign in_dim    = int'(item.element_index) < int'(dims_reg);
    assign load_ok   = (int'(item.row_index) < MAX_ROWS) && (int'(item.element_index) < MAX_DIM);
    assign load_addr = CB_AW'(int'(item.row_index) * MAX_DIM + int'(item.element_index));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && is_query && (in_dim || item.last))
                    begin
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    if (row_reg == last_row_reg)
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (status.pass_done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            row_reg       <= '0;
            addr_reg      <= CB_AW'(item.element_index);
            value_reg     <= item.element_value;
            acc_en_reg    <= in_dim;
            zero_base_reg <= in_dim && (item.element_index == '0);
            emit_reg      <= item.last;
        end
        else if (state_reg == S_ISSUE)
        begin
            row_reg  <= row_reg + RW'(1);
            addr_reg <= addr_reg + CB_AW'(MAX_DIM);
        end
    end

    always_comb
    begin
        issue.valid     = (state_reg == S_ISSUE);
        issue.acc_en    = acc_en_reg;
        issue.zero_base = zero_base_reg;
        issue.first     = (row_reg == '0);
        issue.final_row = (row_reg == last_row_reg);
        issue.emit      = emit_reg;
    end

    ncs_codebook #(
        .DEPTH (CB_DEPTH)
    ) u_codebook (
        .clk     (clk),
        .wr_en   (accept && !is_query && load_ok),
        .wr_addr (load_addr),
        .wr_data (item.element_value),
        .rd_en   (issue.valid && acc_en_reg),
        .rd_addr (addr_reg),
        .rd_data (cb_data)
    );

    ncs_mac #(
        .MAX_ROWS (MAX_ROWS)
    ) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (issue),
        .issue_row    (row_reg),
        .query_value  (value_reg),
        .cb_data      (cb_data),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

    `NCS_ASSERT_NEXT(a_busy_after_query, accept && is_query && (in_dim || item.last), busy)
    `NCS_ASSERT_IMPL(a_done_in_wait, status.pass_done, state_reg == S_WAIT)
    `NCS_ASSERT_NEXT(a_load_stays_idle, accept && !is_query, !busy)

endmodule
